FILE: rtl/bma_pkg.sv
// Shared constants, codes and word types of the block map allocator.
// No dependencies; every other file imports this package.
`default_nettype none

package bma_pkg;

    // block size and blocks per bank are powers of two: divide by them with shifts
    localparam int BLOCKS_PER_BANK = 1024;
    localparam int BLOCK_BYTES     = 32;
    localparam int NUM_BANKS       = 3;

    localparam int ENT_W       = 11;
    localparam int USAGE_SCALE = 100;
    localparam int AOFF_W      = 15;
    localparam int USAGE_W     = 7;

    localparam int IDX_W      = $clog2(BLOCKS_PER_BANK);
    localparam int CNT_W      = $clog2(BLOCKS_PER_BANK + 1);
    localparam int LEFT_W     = (CNT_W > ENT_W) ? CNT_W : ENT_W;
    localparam int ROWS       = NUM_BANKS * BLOCKS_PER_BANK;
    localparam int ADDR_W     = $clog2(ROWS);
    localparam int BANK_IW    = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int BANK_BYTES = BLOCKS_PER_BANK * BLOCK_BYTES;

    localparam int SZ_W    = $clog2(65535 + BLOCK_BYTES);
    localparam int PROD_W  = $clog2(BLOCKS_PER_BANK * USAGE_SCALE + 1);
    localparam int DIV_W   = (SZ_W > PROD_W) ? SZ_W : PROD_W;
    localparam int BLK_SH  = $clog2(BLOCK_BYTES);
    localparam int BANK_SH = $clog2(BLOCKS_PER_BANK);
    localparam int SH_MAX  = (BLK_SH > BANK_SH) ? BLK_SH : BANK_SH;
    localparam int SH_W    = $clog2(SH_MAX + 1);

    localparam logic [1:0] K_ALLOC = 2'd0;
    localparam logic [1:0] K_FREE  = 2'd1;
    localparam logic [1:0] K_QUERY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOMEM = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  bank;
        logic [15:0] size_bytes;
        logic [15:0] free_offset;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [AOFF_W-1:0]  alloc_offset;
        logic [USAGE_W-1:0] usage_percent;
    } t_out_word;

    typedef struct packed {
        logic      vld;
        t_out_word word;
    } t_res;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [SH_W-1:0]  shift;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: rtl/block_map_allocator_unit.sv
// Per word: allocate divides the size, then scans up to 1024 map entries and marks the
// blocks found (oversize stops after the divide); free divides the offset and reads
// entries; query divides; size zero, bad bank, out-of-range free and unused kind do neither.
// Throughput: one word at a time, set by the single map read port and the shared shifter.
// Reset: a clearing pass writes all 3072 map entries, one per cycle, with the input not ready.
// Depends on bma_pkg, bma_div and bma_ctrl.
`default_nettype none

module block_map_allocator_unit import bma_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    t_res      w_res;
    logic      w_take;
    t_div_req  w_div_req;
    t_div_rsp  w_div_rsp;
    logic      r_out_valid;
    t_out_word r_out_word;

    bma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_res      (w_res),
        .i_res_take (w_take),
        .o_div_req  (w_div_req),
        .i_div_rsp  (w_div_rsp)
    );

    bma_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_take = w_res.vld && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_word <= w_res.word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

FILE: rtl/bma_div.sv
// Shared right shifter, one bit per cycle, for divisions by power-of-two constants.
// Depends on bma_pkg for widths and the request/response types.
`default_nettype none

module bma_div import bma_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [SH_W-1:0]  r_cnt;
    logic [DIV_W-1:0] r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.shift;
                r_quo  <= i_req.dividend;
            end else if (r_busy) begin
                r_quo  <= {1'b0, r_quo[DIV_W-1:1]};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == SH_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

`default_nettype wire

FILE: rtl/bma_ctrl.sv
// Request sequencer: block map memory, per-bank used counts, scan, mark and clear.
// Depends on bma_pkg; drives the shared shifter bma_div.
`default_nettype none

module bma_ctrl import bma_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_word i_in_word,
    output t_res     o_res,
    input  logic     i_res_take,
    output t_div_req o_div_req,
    input  t_div_rsp i_div_rsp
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_QMUL = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_MARK = 3'd5;
    localparam logic [2:0] S_FCLR = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [ENT_W-1:0] mem [ROWS];

    logic [2:0]         r_state,  n_state;
    logic [1:0]         r_kind,   n_kind;
    logic [1:0]         r_bank,   n_bank;
    logic [ADDR_W-1:0]  r_base,   n_base;
    logic [CNT_W-1:0]   r_need,   n_need;
    logic [CNT_W-1:0]   r_run,    n_run;
    logic [IDX_W-1:0]   r_rpos,   n_rpos;
    logic               r_rmore,  n_rmore;
    logic               r_dv,     n_dv;
    logic [IDX_W-1:0]   r_dpos,   n_dpos;
    logic               r_first,  n_first;
    logic [LEFT_W-1:0]  r_left,   n_left;
    logic [IDX_W-1:0]   r_wpos,   n_wpos;
    logic [ADDR_W-1:0]  r_caddr,  n_caddr;
    logic [1:0]         r_status, n_status;
    logic [AOFF_W-1:0]  r_aoff,   n_aoff;
    logic [USAGE_W-1:0] r_usage,  n_usage;
    logic [CNT_W-1:0]   r_used [NUM_BANKS];
    logic [ENT_W-1:0]   r_rdata;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa;
    logic [ENT_W-1:0]   mem_wd;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_ra;

    logic               used_we;
    logic [CNT_W-1:0]   used_val;

    logic [BANK_IW-1:0] w_bidx;
    logic [BANK_IW-1:0] w_in_bidx;
    logic               w_accept;
    logic               w_bank_ok;
    logic [IDX_W-1:0]   w_end;
    logic [CNT_W-1:0]   w_run_new;
    logic [LEFT_W-1:0]  w_left_cur;
    logic [31:0]        w_off_full;

    assign w_bidx     = r_bank[BANK_IW-1:0];
    assign w_in_bidx  = i_in_word.bank[BANK_IW-1:0];
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_bank_ok  = (32'(i_in_word.bank) < NUM_BANKS);
    assign w_end      = (r_state == S_SCAN) ? '0 : IDX_W'(BLOCKS_PER_BANK - 1);
    assign w_run_new  = (r_rdata == '0) ? r_run + 1'b1 : '0;
    assign w_left_cur = r_first ? LEFT_W'(r_rdata) : r_left;
    assign w_off_full = 32'(r_dpos) * 32'(BLOCK_BYTES);

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_bank   = r_bank;
        n_base   = r_base;
        n_need   = r_need;
        n_run    = r_run;
        n_rpos   = r_rpos;
        n_rmore  = r_rmore;
        n_dv     = 1'b0;
        n_dpos   = r_dpos;
        n_first  = r_first;
        n_left   = r_left;
        n_wpos   = r_wpos;
        n_caddr  = r_caddr;
        n_status = r_status;
        n_aoff   = r_aoff;
        n_usage  = r_usage;
        mem_we   = 1'b0;
        mem_wa   = r_base + ADDR_W'(r_wpos);
        mem_wd   = '0;
        mem_re   = 1'b0;
        mem_ra   = r_base + ADDR_W'(r_rpos);
        used_we  = 1'b0;
        used_val = r_used[w_bidx];
        o_div_req.start    = 1'b0;
        o_div_req.dividend = '0;
        o_div_req.shift    = SH_W'(BLK_SH);

        // issue one map read a cycle during scan and clear
        if ((r_state == S_SCAN || r_state == S_FCLR) && r_rmore) begin
            mem_re = 1'b1;
            n_dv   = 1'b1;
            n_dpos = r_rpos;
            if (r_rpos == w_end) begin
                n_rmore = 1'b0;
            end else if (r_state == S_SCAN) begin
                n_rpos = r_rpos - 1'b1;
            end else begin
                n_rpos = r_rpos + 1'b1;
            end
        end

        unique case (r_state)
            S_CLR: begin
                mem_we  = 1'b1;
                mem_wa  = r_caddr;
                n_caddr = r_caddr + 1'b1;
                if (r_caddr == ADDR_W'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_kind   = i_in_word.kind;
                    n_bank   = i_in_word.bank;
                    n_base   = ADDR_W'(32'(w_in_bidx) * BLOCKS_PER_BANK);
                    n_status = ST_OK;
                    n_aoff   = '0;
                    n_usage  = '0;
                    n_state  = S_DONE;
                    unique case (i_in_word.kind)
                        K_ALLOC: begin
                            if (!w_bank_ok || i_in_word.size_bytes == '0) begin
                                n_status = ST_NOMEM;
                            end else begin
                                o_div_req.start    = 1'b1;
                                o_div_req.dividend = DIV_W'(i_in_word.size_bytes)
                                                   + DIV_W'(BLOCK_BYTES - 1);
                                n_state            = S_DIV;
                            end
                        end
                        K_FREE: begin
                            if (!w_bank_ok || 32'(i_in_word.free_offset) >= BANK_BYTES) begin
                                n_status = ST_RANGE;
                            end else begin
                                o_div_req.start    = 1'b1;
                                o_div_req.dividend = DIV_W'(i_in_word.free_offset);
                                n_state            = S_DIV;
                            end
                        end
                        K_QUERY: begin
                            if (w_bank_ok) begin
                                n_state = S_QMUL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_QMUL: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = DIV_W'(32'(r_used[w_bidx]) * 32'(USAGE_SCALE));
                o_div_req.shift    = SH_W'(BANK_SH);
                n_state            = S_DIV;
            end
            S_DIV: begin
                if (i_div_rsp.done) begin
                    unique case (r_kind)
                        K_ALLOC: begin
                            if (i_div_rsp.quot > DIV_W'(BLOCKS_PER_BANK)) begin
                                n_status = ST_NOMEM;
                                n_state  = S_DONE;
                            end else begin
                                n_need  = CNT_W'(i_div_rsp.quot);
                                n_run   = '0;
                                n_rpos  = IDX_W'(BLOCKS_PER_BANK - 1);
                                n_rmore = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        K_FREE: begin
                            n_rpos  = i_div_rsp.quot[IDX_W-1:0];
                            n_rmore = 1'b1;
                            n_first = 1'b1;
                            n_state = S_FCLR;
                        end
                        default: begin
                            n_usage = i_div_rsp.quot[USAGE_W-1:0];
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_dv) begin
                    n_run = w_run_new;
                    if (w_run_new == r_need) begin
                        n_wpos  = r_dpos;
                        n_left  = LEFT_W'(r_need);
                        n_aoff  = w_off_full[AOFF_W-1:0];
                        n_state = S_MARK;
                    end else if (r_dpos == '0) begin
                        n_status = ST_NOMEM;
                        n_state  = S_DONE;
                    end
                end
            end
            S_MARK: begin
                mem_we = 1'b1;
                mem_wd = ENT_W'(r_need);
                n_wpos = r_wpos + 1'b1;
                n_left = r_left - 1'b1;
                if (r_left == LEFT_W'(1)) begin
                    used_we  = 1'b1;
                    used_val = r_used[w_bidx] + r_need;
                    n_state  = S_DONE;
                end
            end
            S_FCLR: begin
                if (r_dv) begin
                    n_first = 1'b0;
                    if (w_left_cur == '0) begin
                        n_state = S_DONE;
                    end else begin
                        if (r_rdata != '0) begin
                            mem_we = 1'b1;
                            mem_wa = r_base + ADDR_W'(r_dpos);
                            if (r_used[w_bidx] != '0) begin
                                used_we  = 1'b1;
                                used_val = r_used[w_bidx] - 1'b1;
                            end
                        end
                        n_left = w_left_cur - 1'b1;
                        if (w_left_cur == LEFT_W'(1) ||
                            r_dpos == IDX_W'(BLOCKS_PER_BANK - 1)) begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_caddr <= '0;
            r_rmore <= 1'b0;
            r_dv    <= 1'b0;
            for (int b = 0; b < NUM_BANKS; b++) begin
                r_used[b] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_caddr <= n_caddr;
            r_rmore <= n_rmore;
            r_dv    <= n_dv;
            if (used_we) begin
                r_used[w_bidx] <= used_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_bank   <= n_bank;
        r_base   <= n_base;
        r_need   <= n_need;
        r_run    <= n_run;
        r_rpos   <= n_rpos;
        r_dpos   <= n_dpos;
        r_first  <= n_first;
        r_left   <= n_left;
        r_wpos   <= n_wpos;
        r_status <= n_status;
        r_aoff   <= n_aoff;
        r_usage  <= n_usage;
    end

    assign o_res.vld                = (r_state == S_DONE);
    assign o_res.word.status        = r_status;
    assign o_res.word.alloc_offset  = r_aoff;
    assign o_res.word.usage_percent = r_usage;

endmodule

`default_nettype wire

FILE: rtl/bma_checker.sv
// Port-level assertions for block_map_allocator_unit, attached by bind.
// Depends on bma_pkg for the word types and status codes.
`default_nettype none

module bma_checker import bma_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped before accept");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_word))
        else $error("stalled result word changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready while a word is in work");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.status == ST_OK || o_out_word.status == ST_NOMEM ||
                         o_out_word.status == ST_RANGE) &&
                        o_out_word.usage_percent <= USAGE_W'(USAGE_SCALE))
        else $error("result status or usage out of range");

    a_offset_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != ST_OK |-> o_out_word.alloc_offset == '0)
        else $error("offset given with a failing status");

endmodule

bind block_map_allocator_unit bma_checker u_bma_checker (.*);

`default_nettype wire
